### rtl/prq_pkg.sv
// Shared types, constants and codes for the priority run queue.
`default_nettype none

package prq_pkg;

  localparam int QUEUE_SLOTS = 64;
  localparam int PRIO_LIMIT  = 128;

  localparam int KIND_W = 2;
  localparam int ID_W   = 6;
  localparam int PRIO_W = 7;
  localparam int STAT_W = 2;

  localparam int PTR_W = $clog2(QUEUE_SLOTS);
  localparam int CNT_W = $clog2(QUEUE_SLOTS + 1);
  localparam int NUM_IDS = 2 ** ID_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SELECT = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   proc_id;
    logic [PRIO_W-1:0] priority_req;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   chosen_id;
    logic [PRIO_W-1:0] chosen_priority;
  } res_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             clear;
    logic             valid;
    logic             is_sel;
    logic [PTR_W-1:0] idx;
  } scan_ctl_t;

  typedef struct packed {
    logic              found;
    logic [PTR_W-1:0]  pos;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } best_t;

endpackage

`default_nettype wire

### rtl/priority_run_queue.sv
// Top level: ordered ready queue with insert, remove and select-best commands.
// Insert, refused commands and kind 3 strobe done_o straight from the exec state;
//   remove and select first scan the queue from the head, then run the unlink
//   shift, which ends with the result strobe.
// One command at a time; busy stays high until the result strobe.
// Reset (async, active low) empties the queue; done_o is a strobe, no stall.
`default_nettype none

module priority_run_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire prq_pkg::cmd_t   cmd_i,
  output logic                 busy,
  output logic                 done_o,
  output prq_pkg::res_t        res_o
);

  localparam int PTR_W = prq_pkg::PTR_W;
  localparam int CNT_W = prq_pkg::CNT_W;
  localparam logic [PTR_W:0]   SlotsWrap = (PTR_W + 1)'(prq_pkg::QUEUE_SLOTS);
  localparam logic [PTR_W-1:0] LastPtr   = PTR_W'(prq_pkg::QUEUE_SLOTS - 1);
  localparam logic [CNT_W-1:0] FullCnt   = CNT_W'(prq_pkg::QUEUE_SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT
  } state_e;

  // Map a logical queue position (head = 0) to a RAM address.
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                            input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= SlotsWrap) begin
      sum = sum - SlotsWrap;
    end
    return sum[PTR_W-1:0];
  endfunction

  // Control and queue bookkeeping
  state_e                        state_q, state_d;
  prq_pkg::cmd_t                 cmd_q, cmd_d;
  logic [PTR_W-1:0]              head_q, head_d;
  logic [CNT_W-1:0]              count_q, count_d;
  logic [prq_pkg::NUM_IDS-1:0]   present_q, present_d;

  // Scan pointers: rk is the next position to read, rv/ridx tag the RAM data.
  logic [CNT_W-1:0]              rk_q, rk_d;
  logic                          rv_q, rv_d;
  logic [PTR_W-1:0]              ridx_q, ridx_d;

  // Shift pointers: sh_rem entries still to move, wv/widx tag the pending write.
  logic [CNT_W-1:0]              sh_rem_q, sh_rem_d;
  logic                          wv_q, wv_d;
  logic [PTR_W-1:0]              widx_q, widx_d;

  prq_pkg::res_t                 res_q, res_d;
  logic                          done_q, done_d;

  // RAM and compare unit hookup
  logic                          ram_we;
  logic [PTR_W-1:0]              ram_waddr;
  prq_pkg::entry_t               ram_wdata;
  logic [PTR_W-1:0]              ram_raddr;
  prq_pkg::entry_t               ram_rdata;
  prq_pkg::scan_ctl_t            scan_ctl;
  prq_pkg::best_t                best;

  logic [CNT_W-1:0]              sh_prev;
  logic [PTR_W-1:0]              head_dec;
  logic [PTR_W-1:0]              head_inc;
  logic [prq_pkg::PRIO_W-1:0]    prio_sat;
  logic                          is_sel;

  assign sh_prev  = sh_rem_q - CNT_W'(1);
  assign head_dec = (head_q == '0) ? LastPtr : head_q - PTR_W'(1);
  assign head_inc = (head_q == LastPtr) ? '0 : head_q + PTR_W'(1);
  assign is_sel   = (cmd_q.kind == prq_pkg::KIND_SELECT);

  // Clamp so every stored entry stays selectable.
  assign prio_sat = (int'(cmd_q.priority_req) >= prq_pkg::PRIO_LIMIT) ?
                    prq_pkg::PRIO_W'(prq_pkg::PRIO_LIMIT - 1) : cmd_q.priority_req;

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    head_d    = head_q;
    count_d   = count_q;
    present_d = present_q;
    rk_d      = rk_q;
    rv_d      = 1'b0;
    ridx_d    = ridx_q;
    sh_rem_d  = sh_rem_q;
    wv_d      = 1'b0;
    widx_d    = widx_q;
    res_d     = res_q;
    done_d    = 1'b0;

    ram_we    = 1'b0;
    ram_waddr = phys(head_q, widx_q);
    ram_wdata = ram_rdata;
    ram_raddr = phys(head_q, rk_q[PTR_W-1:0]);

    scan_ctl  = '{clear: 1'b0, valid: rv_q, is_sel: is_sel, idx: ridx_q};

    case (state_q)
      S_IDLE: begin
        // Take a command beat.
        if (start) begin
          cmd_d   = cmd_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_d       = '0;
        res_d.status = prq_pkg::ST_OK;
        scan_ctl.clear = 1'b1;
        rk_d = '0;
        case (cmd_q.kind)
          prq_pkg::KIND_INSERT: begin
            if (present_q[cmd_q.proc_id] || (count_q == FullCnt)) begin
              res_d.status = prq_pkg::ST_DUP;
            end else begin
              // Push at the head: step the head back and write there.
              ram_we    = 1'b1;
              ram_waddr = head_dec;
              ram_wdata = '{id: cmd_q.proc_id, prio: prio_sat};
              head_d    = head_dec;
              count_d   = count_q + CNT_W'(1);
              present_d[cmd_q.proc_id] = 1'b1;
            end
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          prq_pkg::KIND_REMOVE: begin
            if (!present_q[cmd_q.proc_id]) begin
              res_d.status = prq_pkg::ST_MISSING;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              state_d = S_SCAN;
            end
          end
          prq_pkg::KIND_SELECT: begin
            if (count_q == '0) begin
              res_d.status = prq_pkg::ST_EMPTY;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              state_d = S_SCAN;
            end
          end
          default: begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end

      S_SCAN: begin
        // Read one entry per cycle from the head; the compare unit sees it next cycle.
        if (rk_q != count_q) begin
          rk_d   = rk_q + CNT_W'(1);
          rv_d   = 1'b1;
          ridx_d = rk_q[PTR_W-1:0];
        end else if (!rv_q) begin
          sh_rem_d = CNT_W'(best.pos);
          state_d  = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // Close the gap: move entries in front of pos one place toward the tail.
        ram_raddr = phys(head_q, sh_prev[PTR_W-1:0]);
        ram_we    = wv_q;
        if (sh_rem_q != '0) begin
          sh_rem_d = sh_prev;
          wv_d     = 1'b1;
          widx_d   = sh_rem_q[PTR_W-1:0];
        end else if (!wv_q) begin
          // Drop the old head slot and report.
          head_d  = head_inc;
          count_d = count_q - CNT_W'(1);
          present_d[best.id] = 1'b0;
          if (is_sel) begin
            res_d.chosen_id       = best.id;
            res_d.chosen_priority = best.prio;
          end
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      present_q <= '0;
      rk_q      <= '0;
      rv_q      <= 1'b0;
      sh_rem_q  <= '0;
      wv_q      <= 1'b0;
      done_q    <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      present_q <= present_d;
      rk_q      <= rk_d;
      rv_q      <= rv_d;
      sh_rem_q  <= sh_rem_d;
      wv_q      <= wv_d;
      done_q    <= done_d;
      res_q     <= res_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    ridx_q <= ridx_d;
    widx_q <= widx_d;
  end

  // The queue RAM has one read and one write port; scans and the unlink shift
  // each move one entry per cycle through it. Its contents survive reset.
  prq_ram #(
    .WIDTH(prq_pkg::ENTRY_W),
    .DEPTH(prq_pkg::QUEUE_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  prq_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .entry_i (ram_rdata),
    .target_i(cmd_q.proc_id),
    .best_o  (best)
  );

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  // A result beat is a single-cycle strobe.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe held two cycles");

  // Result beats only appear once the sequencer has gone idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy) else $error("result strobe while busy");

  // Presence map and fill count must agree.
  a_count_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(present_q) == int'(count_q)) else $error("presence map out of sync");

  // The queue never overfills.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt) else $error("queue count overflow");

  // Every scan that reaches the unlink shift has found its entry.
  a_shift_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> best.found) else $error("unlink without a found entry");
`endif

endmodule

`default_nettype wire

### rtl/prq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/prq_cmp.sv
// Shared compare unit: tracks the matching or most urgent entry of a scan.
`default_nettype none

module prq_cmp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire prq_pkg::scan_ctl_t            ctl_i,
  input  wire prq_pkg::entry_t               entry_i,
  input  wire logic [prq_pkg::ID_W-1:0]      target_i,
  output prq_pkg::best_t                     best_o
);

  logic                         found_q;
  logic [prq_pkg::PTR_W-1:0]    pos_q;
  logic [prq_pkg::ID_W-1:0]     id_q;
  logic [prq_pkg::PRIO_W-1:0]   prio_q;
  logic                         take;

  // Select: first strictly lower priority wins; remove: first id match.
  always_comb begin
    if (ctl_i.is_sel) begin
      take = ctl_i.valid && (!found_q || (entry_i.prio < prio_q));
    end else begin
      take = ctl_i.valid && !found_q && (entry_i.id == target_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pos_q  <= ctl_i.idx;
      id_q   <= entry_i.id;
      prio_q <= entry_i.prio;
    end
  end

  assign best_o = '{found: found_q, pos: pos_q, id: id_q, prio: prio_q};

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for the priority run queue: directed and random commands.

module tb_top;
  import prq_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 2;
  // Bound on the slowest command: a full scan plus a full unlink shift.
  localparam int MAX_LATENCY = 2 * QUEUE_SLOTS + 8;
  localparam int ITEMS_PER_PHASE = 670;
  // Roughly 2100 beats, each at most MAX_LATENCY plus the longest sender gap,
  // with a 10x margin on top.
  localparam int TIMEOUT_TU = 50_000_000;

  // Mirror of the ready queue and the store of results still owed by the block.
  class run_queue_scoreboard;
    entry_t ready_q[$];
    res_t   owed_results[$];
    int     mismatches;
    int     results_checked;
    int     commands_noted;
    int     status_count[4];
    int     deepest;
    int     full_refusals;
    int     tied_selects;

    function int find_slot(logic [ID_W-1:0] id);
      foreach (ready_q[i])
        if (ready_q[i].id == id)
          return i;
      return -1;
    endfunction

    function int depth();
      return ready_q.size();
    endfunction

    function int owed();
      return owed_results.size();
    endfunction

    task report_mismatch(string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Advance the mirrored queue by one accepted command and queue its result.
    function void note_command(cmd_t c);
      res_t   r;
      entry_t e;
      int     pos;
      int     best;
      int     stored_prio;
      r = '0;
      commands_noted++;
      case (kind_e'(c.kind))
        KIND_INSERT: begin
          if (find_slot(c.proc_id) >= 0 || ready_q.size() >= QUEUE_SLOTS) begin
            r.status = ST_DUP;
            if (ready_q.size() >= QUEUE_SLOTS)
              full_refusals++;
          end else begin
            stored_prio = int'(c.priority_req);
            if (stored_prio >= PRIO_LIMIT)
              stored_prio = PRIO_LIMIT - 1;
            e.id = c.proc_id;
            e.prio = stored_prio[PRIO_W-1:0];
            ready_q.push_front(e);
          end
        end
        KIND_REMOVE: begin
          pos = find_slot(c.proc_id);
          if (pos < 0)
            r.status = ST_MISSING;
          else
            ready_q.delete(pos);
        end
        KIND_SELECT: begin
          if (ready_q.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            best = 0;
            for (int i = 1; i < ready_q.size(); i++)
              if (ready_q[i].prio < ready_q[best].prio)
                best = i;
            for (int i = best + 1; i < ready_q.size(); i++)
              if (ready_q[i].prio == ready_q[best].prio) begin
                tied_selects++;
                break;
              end
            r.chosen_id = ready_q[best].id;
            r.chosen_priority = ready_q[best].prio;
            ready_q.delete(best);
          end
        end
        default: ;
      endcase
      if (ready_q.size() > deepest)
        deepest = ready_q.size();
      owed_results.push_back(r);
    endfunction

    // Compare one result beat with the oldest owed result.
    task check_result(res_t got);
      res_t exp;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing owed (%0d/%0d/%0d)",
                                  got.status, got.chosen_id, got.chosen_priority));
        return;
      end
      exp = owed_results.pop_front();
      results_checked++;
      status_count[exp.status]++;
      if (got.status !== exp.status)
        report_mismatch($sformatf("field status got %0d exp %0d",
                                  got.status, exp.status));
      if (got.chosen_id !== exp.chosen_id)
        report_mismatch($sformatf("field chosen_id got %0d exp %0d",
                                  got.chosen_id, exp.chosen_id));
      if (got.chosen_priority !== exp.chosen_priority)
        report_mismatch($sformatf("field chosen_priority got %0d exp %0d",
                                  got.chosen_priority, exp.chosen_priority));
    endtask
  endclass

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  cmd_t  cmd_i;
  logic  busy;
  logic  done_o;
  res_t  res_o;

  run_queue_scoreboard scoreboard = new();

  int sender_idle_pct;
  int beats_sent;

  priority_run_queue u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // Sample both sides at the rising edge. Retire the owed result before noting
  // a new command, since a result strobe and the next accept can share an edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o)
        scoreboard.check_result(res_o);
      if (start && !busy)
        scoreboard.note_command(cmd_i);
    end
  end

  function automatic cmd_t make_cmd(kind_e k, int id, int prio);
    cmd_t c;
    c.kind = k;
    c.proc_id = id[ID_W-1:0];
    c.priority_req = prio[PRIO_W-1:0];
    return c;
  endfunction

  // Only call while the queue has room; every id is taken once it is full.
  function automatic int pick_absent_id();
    int id;
    do
      id = $urandom_range(0, NUM_IDS - 1);
    while (scoreboard.find_slot(id[ID_W-1:0]) >= 0);
    return id;
  endfunction

  function automatic int pick_present_id();
    return int'(scoreboard.ready_q[$urandom_range(0, scoreboard.depth() - 1)].id);
  endfunction

  // Tie mode crowds priorities onto a few values so earliest-wins gets exercised.
  function automatic int pick_prio(bit tie_mode);
    if (!tie_mode)
      return $urandom_range(0, PRIO_LIMIT - 1);
    return ($urandom_range(0, 3) == 0) ? PRIO_LIMIT - 1 : $urandom_range(0, 2);
  endfunction

  function automatic cmd_t make_random_cmd(bit tie_mode);
    int roll;
    int id;
    roll = $urandom_range(0, 99);
    id = $urandom_range(0, NUM_IDS - 1);
    if (roll < 40) begin
      if (scoreboard.depth() < QUEUE_SLOTS && $urandom_range(0, 9) < 7)
        id = pick_absent_id();
      return make_cmd(KIND_INSERT, id, pick_prio(tie_mode));
    end
    if (roll < 65) begin
      if (scoreboard.depth() > 0 && $urandom_range(0, 9) < 7)
        id = pick_present_id();
      return make_cmd(KIND_REMOVE, id, $urandom_range(0, PRIO_LIMIT - 1));
    end
    if (roll < 93)
      return make_cmd(KIND_SELECT, id, $urandom_range(0, PRIO_LIMIT - 1));
    return make_cmd(KIND_NOP, id, $urandom_range(0, PRIO_LIMIT - 1));
  endfunction

  // For sender_idle_pct percent of calls, hold start low for a random gap. Entered at a falling edge.
  task automatic sender_gap();
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  // Present one command beat and hold it until accepted; return at the next
  // falling edge so start may stay high into the following beat.
  task automatic send_cmd(cmd_t c);
    sender_gap();
    start <= 1'b1;
    cmd_i <= c;
    do
      @(posedge clk_i);
    while (busy);
    @(negedge clk_i);
    beats_sent++;
  endtask

  // Drop start and wait for every owed result, with a cycle limit.
  task automatic wait_for_results(int limit);
    int waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(negedge clk_i);
      waited++;
    end while (scoreboard.owed() != 0 && waited < limit);
  endtask

  // Insert absent slots until the queue is full, then push a few refused inserts.
  task automatic fill_queue(bit tie_mode);
    while (scoreboard.depth() < QUEUE_SLOTS)
      send_cmd(make_cmd(KIND_INSERT, pick_absent_id(), pick_prio(tie_mode)));
    repeat ($urandom_range(1, 3))
      send_cmd(make_cmd(KIND_INSERT, $urandom_range(0, NUM_IDS - 1), pick_prio(tie_mode)));
  endtask

  // Empty the queue mostly by select, partly by remove, then select on empty.
  task automatic drain_queue();
    while (scoreboard.depth() > 0) begin
      if ($urandom_range(0, 4) == 0)
        send_cmd(make_cmd(KIND_REMOVE, pick_present_id(), $urandom_range(0, PRIO_LIMIT - 1)));
      else
        send_cmd(make_cmd(KIND_SELECT, $urandom_range(0, NUM_IDS - 1),
                          $urandom_range(0, PRIO_LIMIT - 1)));
    end
    repeat ($urandom_range(1, 2))
      send_cmd(make_cmd(KIND_SELECT, $urandom_range(0, NUM_IDS - 1),
                        $urandom_range(0, PRIO_LIMIT - 1)));
  endtask

  task automatic run_directed();
    send_cmd(make_cmd(KIND_SELECT, 63, 127));  // select on an empty queue
    send_cmd(make_cmd(KIND_REMOVE, 63, 0));    // remove of an absent slot
    send_cmd(make_cmd(KIND_NOP, 42, 85));      // unused kind does nothing
    send_cmd(make_cmd(KIND_INSERT, 0, 127));
    send_cmd(make_cmd(KIND_INSERT, 63, 0));
    send_cmd(make_cmd(KIND_INSERT, 21, 0));    // tie with slot 63; head wins
    send_cmd(make_cmd(KIND_INSERT, 42, 64));
    send_cmd(make_cmd(KIND_INSERT, 0, 5));     // duplicate insert is refused
    send_cmd(make_cmd(KIND_REMOVE, 42, 127));  // unlink from the head
    send_cmd(make_cmd(KIND_REMOVE, 42, 0));    // now absent
    send_cmd(make_cmd(KIND_SELECT, 0, 0));
    send_cmd(make_cmd(KIND_SELECT, 0, 0));
    send_cmd(make_cmd(KIND_INSERT, 63, 127));  // tie at the top priority value
    send_cmd(make_cmd(KIND_SELECT, 21, 85));
    send_cmd(make_cmd(KIND_REMOVE, 0, 42));    // last entry leaves
    send_cmd(make_cmd(KIND_REMOVE, 0, 42));
    send_cmd(make_cmd(KIND_SELECT, 42, 21));
    send_cmd(make_cmd(KIND_NOP, 0, 0));
  endtask

  // Mix segments: fill to the top, drain to empty, or random commands.
  task automatic run_random_phase(int target, bit force_fill);
    int mode;
    bit tie_mode;
    int stop_at;
    stop_at = beats_sent + target;
    if (force_fill)
      fill_queue(1'b0);
    while (beats_sent < stop_at) begin
      mode = $urandom_range(0, 9);
      tie_mode = ($urandom_range(0, 9) < 3);
      if (mode < 2)
        fill_queue(tie_mode);
      else if (mode < 4)
        drain_queue();
      else
        repeat ($urandom_range(20, 60))
          send_cmd(make_random_cmd(tie_mode));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    sender_idle_pct = 0;
    beats_sent = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    sender_idle_pct = 32;
    run_directed();
    // Pause the sender until everything owed has come back.
    wait_for_results(MAX_LATENCY * 4);

    run_random_phase(ITEMS_PER_PHASE, 1'b1);
    wait_for_results(MAX_LATENCY * 4);
    sender_idle_pct = 78;
    run_random_phase(ITEMS_PER_PHASE, 1'b0);
    wait_for_results(MAX_LATENCY * 4);
    sender_idle_pct = 0;
    run_random_phase(ITEMS_PER_PHASE, 1'b0);

    wait_for_results(MAX_LATENCY * 4);
    repeat (MAX_LATENCY) @(negedge clk_i);
    while (scoreboard.owed() != 0) begin
      void'(scoreboard.owed_results.pop_front());
      scoreboard.report_mismatch("owed result never arrived");
    end

    $display("covered %0d command beats, %0d results checked (ok %0d, dup %0d, missing %0d, empty %0d)",
             scoreboard.commands_noted, scoreboard.results_checked,
             scoreboard.status_count[ST_OK], scoreboard.status_count[ST_DUP],
             scoreboard.status_count[ST_MISSING], scoreboard.status_count[ST_EMPTY]);
    $display("deepest queue %0d entries, %0d inserts refused when full, %0d tied selects",
             scoreboard.deepest, scoreboard.full_refusals, scoreboard.tied_selects);
    if (scoreboard.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    #TIMEOUT_TU;
    $display("timeout after %0d beats", beats_sent);
    $display("status: fail");
    $finish;
  end

endmodule
